### sv/board_bus_decoder_keypad_assert.svh
// Assertion macros for the board bus decoder and keypad block.
// Used by the top level; needs a clock named clk and a reset named rst in scope.
`ifndef BOARD_BUS_DECODER_KEYPAD_ASSERT_SVH
`define BOARD_BUS_DECODER_KEYPAD_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define BBDK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbdk assertion failed");

// Next-cycle implication, disabled in reset
`define BBDK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbdk assertion failed");

`endif

### sv/bbdk_pkg.sv
// Shared types and constants for the board bus decoder and keypad block.
// No dependencies; imported by bbdk_ctrl, bbdk_datapath and the top level.
package bbdk_pkg;

  // Default memory sizes (powers of two)
  localparam int DEF_RAM_BYTES = 2048;
  localparam int DEF_ROM_BYTES = 32768;

  // Field widths
  localparam int OP_W      = 3;
  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int KEY_W     = 9;
  localparam int REL_W     = 20;
  localparam int NMI_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 20;

  // Opcodes
  typedef enum logic [OP_W-1:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_TICK    = 3'd2,
    OP_SET_KEY = 3'd3,
    OP_ROM_LOAD = 3'd4
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELEASE_TICKS = 2'd0,
    CFG_NMI_PERIOD    = 2'd1
  } cfg_idx_t;

  // Memory map
  localparam logic [ADDR_W-1:0] ADDR_PANEL_MUX  = 16'h2000;
  localparam logic [ADDR_W-1:0] ADDR_ROW_SELECT = 16'h2800;
  localparam logic [ADDR_W-4:0] ADDR_KEYPAD_HI  = 13'h0600; // 0x3000 >> 3

  // Keypad answers and reset values
  localparam logic [DATA_W-1:0] KEY_IDLE        = 8'h80;
  localparam logic [DATA_W-1:0] KEY_HIT         = 8'h00;
  localparam logic [KEY_W-1:0]  NO_KEY          = 9'h1FF;
  localparam logic [REL_W-1:0]  RELEASE_DEFAULT = 20'd500000;
  localparam logic [NMI_W-1:0]  NMI_DEFAULT     = 16'd4096;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch input word and read memories
    logic commit;   // update state and load output register
  } cmd_t;

endpackage

### sv/board_bus_decoder_keypad.sv
// Channel  Direction  Handshake              Word
// in       input      in_valid / in_ready    opcode, address, write_data, key_code
// out      output     out_valid / out_ready  read_data, nmi_pulse
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A word passes capture and commit: memories are read at acceptance, then state is
// updated and the result registered at commit; no new word is taken until then.
// A result waiting in the output register holds off the commit of the next word
// until it is taken; no new word is accepted meanwhile.
// Reset restores latches, key, timers and configuration; RAM and ROM are not cleared.
// Top level of the board bus decoder and keypad; uses bbdk_pkg, bbdk_ctrl, bbdk_datapath.
`include "board_bus_decoder_keypad_assert.svh"

module board_bus_decoder_keypad import bbdk_pkg::*; #(
  parameter int RAM_BYTES = DEF_RAM_BYTES,
  parameter int ROM_BYTES = DEF_ROM_BYTES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         opcode,
  input  logic [ADDR_W-1:0]       address,
  input  logic [DATA_W-1:0]       write_data,
  input  logic signed [KEY_W-1:0] key_code,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DATA_W-1:0]       read_data,
  output logic                    nmi_pulse,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  cmd_t cmd;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  bbdk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bbdk_datapath #(
    .RAM_BYTES (RAM_BYTES),
    .ROM_BYTES (ROM_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .opcode     (opcode),
    .address    (address),
    .write_data (write_data),
    .key_code   (key_code),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .read_data  (read_data),
    .nmi_pulse  (nmi_pulse)
  );

  // Busy in the cycle after a word is accepted
  `BBDK_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // A commit always leaves a result waiting
  `BBDK_ASSERT_NEXT(a_commit_fills_out, cmd.commit, out_valid)
  // A result only appears through a commit
  `BBDK_ASSERT_NOW(a_out_from_commit, $rose(out_valid), $past(cmd.commit))

endmodule

### sv/bbdk_ctrl.sv
// Controller: sequences one input word through capture and commit.
// Depends on bbdk_pkg.
module bbdk_ctrl import bbdk_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.capture    = 1'b0;
    cmd.commit     = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // commit once the output register is free or being emptied
        if (!out_valid || out_ready) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### sv/bbdk_datapath.sv
// Datapath: input latch, work RAM, program ROM, latches, timers and output register.
// Depends on bbdk_pkg; driven by bbdk_ctrl commands.
module bbdk_datapath import bbdk_pkg::*; #(
  parameter int RAM_BYTES = DEF_RAM_BYTES,
  parameter int ROM_BYTES = DEF_ROM_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [OP_W-1:0]       opcode,
  input  logic [ADDR_W-1:0]     address,
  input  logic [DATA_W-1:0]     write_data,
  input  logic signed [KEY_W-1:0] key_code,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic [DATA_W-1:0]     read_data,
  output logic                  nmi_pulse
);

  localparam int RAM_AW = $clog2(RAM_BYTES);
  localparam int ROM_AW = $clog2(ROM_BYTES);
  localparam logic [ADDR_W:0] RAM_LIMIT = (ADDR_W+1)'(RAM_BYTES);
  localparam logic [ADDR_W:0] ROM_LIMIT = (ADDR_W+1)'(ROM_BYTES);

  // Latched input word
  logic [OP_W-1:0]   op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;
  logic [KEY_W-1:0]  key_q;

  // Memories
  logic [DATA_W-1:0] ram_mem [RAM_BYTES];
  logic [DATA_W-1:0] rom_mem [ROM_BYTES];
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] rom_rdata;

  // Architectural state
  logic [DATA_W-1:0] panel_mux;
  logic [DATA_W-1:0] row_select;
  logic [KEY_W-1:0]  pressed_key;
  logic [REL_W-1:0]  release_count;
  logic [NMI_W-1:0]  nmi_count;
  logic [REL_W-1:0]  release_ticks;
  logic [NMI_W-1:0]  nmi_period;

  // Decode and combinational results
  logic              ram_hit;
  logic              rom_load_ok;
  logic              keypad_hit;
  logic [7:0]        key_base;
  logic [DATA_W-1:0] key_bit;
  logic [DATA_W-1:0] rd_value;
  logic [REL_W-1:0]  release_dec;
  logic              nmi_fire;

  // Input latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= opcode;
      addr_q  <= address;
      wdata_q <= write_data;
      key_q   <= key_code;
    end
  end

  // Work RAM: read with the incoming address, write at commit
  always_ff @(posedge clk) begin
    if (cmd.capture) ram_rdata <= ram_mem[address[RAM_AW-1:0]];
    if (cmd.commit && op_q == OP_WRITE && ram_hit &&
        addr_q != ADDR_PANEL_MUX && addr_q != ADDR_ROW_SELECT) begin
      ram_mem[addr_q[RAM_AW-1:0]] <= wdata_q;
    end
  end

  // Program ROM: window at 0x8000 wraps modulo its size
  always_ff @(posedge clk) begin
    if (cmd.capture) rom_rdata <= rom_mem[address[ROM_AW-1:0]];
    if (cmd.commit && op_q == OP_ROM_LOAD && rom_load_ok) begin
      rom_mem[addr_q[ROM_AW-1:0]] <= wdata_q;
    end
  end

  assign ram_hit     = {1'b0, addr_q} < RAM_LIMIT;
  assign rom_load_ok = {1'b0, addr_q} < ROM_LIMIT;
  assign keypad_hit  = addr_q[ADDR_W-1:3] == ADDR_KEYPAD_HI;

  // Keypad base: panel mux bits first, then one cleared row bit
  always_comb begin
    key_base = 8'd0;
    if (panel_mux[0])      key_base = 8'd136;
    else if (panel_mux[1]) key_base = 8'd140;
    else if (panel_mux[2]) key_base = 8'd128;
    else if (panel_mux[3]) key_base = 8'd132;
    else begin
      for (int n = 1; n < 8; n++) begin
        if (row_select == ~(8'd1 << n)) key_base = 8'(8 * n);
      end
    end
  end

  always_comb begin
    if (pressed_key[KEY_W-1]) key_bit = KEY_IDLE;
    else if (pressed_key == {1'b0, key_base + {5'd0, addr_q[2:0]}}) key_bit = KEY_HIT;
    else key_bit = KEY_IDLE;
  end

  // Read decode in priority order
  always_comb begin
    if (addr_q[ADDR_W-1]) rd_value = rom_rdata;
    else if (ram_hit)     rd_value = ram_rdata;
    else if (keypad_hit)  rd_value = key_bit;
    else                  rd_value = '0;
  end

  assign release_dec = (release_count != '0) ? release_count - 1'b1 : release_count;
  assign nmi_fire    = nmi_count <= NMI_W'(1);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      release_ticks <= RELEASE_DEFAULT;
      nmi_period    <= NMI_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RELEASE_TICKS: release_ticks <= cfg_data[REL_W-1:0];
        CFG_NMI_PERIOD:    nmi_period    <= cfg_data[NMI_W-1:0];
        default: ;
      endcase
    end
  end

  // Latches, key and timers, updated at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_mux     <= '0;
      row_select    <= '0;
      pressed_key   <= NO_KEY;
      release_count <= '0;
      nmi_count     <= NMI_W'(1);
    end else if (cmd.commit) begin
      case (op_q)
        OP_WRITE: begin
          if (addr_q == ADDR_PANEL_MUX)       panel_mux  <= ~wdata_q;
          else if (addr_q == ADDR_ROW_SELECT) row_select <= wdata_q;
        end
        OP_TICK: begin
          release_count <= release_dec;
          if (release_dec == '0) pressed_key <= NO_KEY;
          nmi_count <= nmi_fire ? nmi_period : nmi_count - 1'b1;
        end
        OP_SET_KEY: begin
          pressed_key   <= key_q;
          release_count <= release_ticks;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      read_data <= (op_q == OP_READ) ? rd_value : '0;
      nmi_pulse <= (op_q == OP_TICK) && nmi_fire;
    end
  end

endmodule
